@@ rtl/core/cxe_pkg.sv @@
// Shared types, constants and escape tables for the chained XOR cipher.
`timescale 1ns / 1ps

package cxe_pkg;

    // Largest number of key bytes that the key position cycles through.
    localparam int MAX_KEY_BYTES_DEF = 8;

    localparam int KEY_W     = 64;
    localparam int KEY_LEN_W = 4;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    // Raw cipher values that are escaped, and the characters that follow the backslash.
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SOH       = 8'h01;
    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_A         = 8'h61;
    localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CH_N         = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R         = 8'h72;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] val;
    } t_map;

    // Cipher byte to escape character; hit is low for bytes sent unchanged.
    function automatic t_map escape_of(input logic [BYTE_W-1:0] c);
        t_map m;
        m.hit = 1'b1;
        m.val = '0;
        case (c)
            CH_SOH:       m.val = CH_A;
            CH_BACKSLASH: m.val = CH_BACKSLASH;
            CH_NUL:       m.val = CH_ZERO;
            CH_LF:        m.val = CH_N;
            CH_CR:        m.val = CH_R;
            default:      m.hit = 1'b0;
        endcase
        return m;
    endfunction

    // Escape character to cipher byte; hit is low for an unknown pair.
    function automatic t_map unescape_of(input logic [BYTE_W-1:0] b);
        t_map m;
        m.hit = 1'b1;
        m.val = '0;
        case (b)
            CH_A:         m.val = CH_SOH;
            CH_BACKSLASH: m.val = CH_BACKSLASH;
            CH_ZERO:      m.val = CH_NUL;
            CH_N:         m.val = CH_LF;
            CH_R:         m.val = CH_CR;
            default:      m.hit = 1'b0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/chained_xor_cipher_with_escaping.sv @@
// Top level of the chained XOR byte cipher with escaping and unescaping.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one message byte per beat: s_axis_tdata is the byte,
// s_axis_tuser selects encrypt (0) or decrypt (1), and s_axis_tlast marks the
// last byte of a message. The master stream carries result bytes, with
// m_axis_tlast high on the final result byte caused by one input beat.
// An encrypt beat gives one byte, or two (backslash, then a letter) when the
// cipher byte must be escaped. A decrypt beat gives one plaintext byte, or none
// when it is a backslash that opens an escape, an unknown escape pair, or a
// backslash left dangling at the end of a message.
// An accepted input beat passes through the input register, then the result
// register, before its first result beat. One beat is taken per cycle while the
// receiver takes results; a two-byte escape holds the input register until the
// backslash has left the result register. Key bytes and key length are written
// through the configuration port while the stream is idle; the user must keep to
// this, as the block does not enforce it. Reset clears the chain byte, key
// position and escape flag, empties both registers, and sets the key to zero with
// length one. When the receiver stalls, results wait in the result register and
// one more input beat waits in the input register before s_axis_tready falls.
module chained_xor_cipher_with_escaping #(
    parameter int MAX_KEY_BYTES = cxe_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port
    input  logic                         i_cfg_we,
    input  logic [cxe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cxe_pkg::KEY_W-1:0]    i_cfg_wdata,
    // Slave stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [cxe_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] in_byte
    input  logic                         s_axis_tuser,   // [0] op
    input  logic                         s_axis_tlast,   // end_of_message
    // Master stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [cxe_pkg::BYTE_W-1:0]   m_axis_tdata,   // [7:0] out_byte
    output logic                         m_axis_tlast    // last_of_run
);
    import cxe_pkg::*;

    localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    // Configuration registers.
    logic [KEY_W-1:0]     r_key_bytes;
    logic [KEY_LEN_W-1:0] r_key_length;

    // Input register.
    logic              r_in_valid, n_in_valid;
    t_op               r_in_op, n_in_op;
    logic [BYTE_W-1:0] r_in_byte, n_in_byte;
    logic              r_in_eom, n_in_eom;

    // Cipher state.
    logic [BYTE_W-1:0] r_chain, n_chain;
    logic [KPOS_W-1:0] r_kpos, n_kpos;
    logic              r_esc_pend, n_esc_pend;

    // Result register: up to two bytes, byte 0 is presented first.
    logic [1:0]        r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_b0, n_b0, r_b1, n_b1;
    logic              r_l0, n_l0, r_l1, n_l1;

    logic              pop;
    logic              consume;
    logic [BYTE_W-1:0] key_byte;
    logic [KEY_LEN_W-1:0] used_len;
    logic [KEY_LEN_W-1:0] next_pos;
    logic [KPOS_W-1:0] adv_pos;
    t_map              enc_map;
    t_map              dec_map;
    logic [BYTE_W-1:0] enc_c;
    logic [BYTE_W-1:0] dec_c;
    logic [BYTE_W-1:0] dec_p;
    logic              dec_have;
    logic [1:0]        res_cnt;
    logic [BYTE_W-1:0] res_b0, res_b1;
    logic              res_l0;

    // The result register can take a new item when it is empty, or when its
    // single byte leaves in this cycle.
    assign pop     = m_axis_tvalid && m_axis_tready;
    assign consume = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready));
    assign s_axis_tready = !r_in_valid || consume;

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_b0;
    assign m_axis_tlast  = r_l0;

    // Key byte at the current position; a stale position past a shortened
    // key still selects its own byte and wraps afterwards.
    assign key_byte = r_key_bytes[{r_kpos, 3'b000} +: BYTE_W];

    always_comb begin
        used_len = r_key_length;
        if (r_key_length == '0) begin
            used_len = KEY_LEN_W'(1);
        end else if (r_key_length > MAX_LEN) begin
            used_len = MAX_LEN;
        end
        next_pos = KEY_LEN_W'(r_kpos) + KEY_LEN_W'(1);
        adv_pos  = (next_pos >= used_len) ? '0 : next_pos[KPOS_W-1:0];
    end

    // Encrypt path.
    assign enc_c   = r_chain ^ r_in_byte ^ key_byte;
    assign enc_map = escape_of(enc_c);

    // Decrypt path: a byte after a backslash is looked up, a lone byte passes.
    assign dec_map  = unescape_of(r_in_byte);
    assign dec_c    = r_esc_pend ? dec_map.val : r_in_byte;
    assign dec_have = r_esc_pend ? dec_map.hit : (r_in_byte != CH_BACKSLASH);
    assign dec_p    = r_chain ^ dec_c ^ key_byte;

    always_comb begin
        n_chain    = r_chain;
        n_kpos     = r_kpos;
        n_esc_pend = r_esc_pend;
        res_cnt    = 2'd0;
        res_b0     = '0;
        res_b1     = '0;
        res_l0     = 1'b1;
        if (r_in_op == OP_ENCRYPT) begin
            n_chain = r_chain ^ r_in_byte;
            n_kpos  = adv_pos;
            if (enc_map.hit) begin
                res_cnt = 2'd2;
                res_b0  = CH_BACKSLASH;
                res_l0  = 1'b0;
                res_b1  = enc_map.val;
            end else begin
                res_cnt = 2'd1;
                res_b0  = enc_c;
            end
        end else begin
            n_esc_pend = !r_esc_pend && (r_in_byte == CH_BACKSLASH);
            if (dec_have) begin
                n_chain = r_chain ^ dec_p;
                n_kpos  = adv_pos;
                res_cnt = 2'd1;
                res_b0  = dec_p;
            end
        end
        if (r_in_eom) begin
            n_chain    = '0;
            n_kpos     = '0;
            n_esc_pend = 1'b0;
        end
        if (!consume) begin
            n_chain    = r_chain;
            n_kpos     = r_kpos;
            n_esc_pend = r_esc_pend;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        n_b0  = r_b0;
        n_l0  = r_l0;
        n_b1  = r_b1;
        n_l1  = r_l1;
        if (consume) begin
            n_cnt = res_cnt;
            n_b0  = res_b0;
            n_l0  = res_l0;
            n_b1  = res_b1;
            n_l1  = 1'b1;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
            n_b0  = r_b1;
            n_l0  = r_l1;
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        n_in_op    = r_in_op;
        n_in_byte  = r_in_byte;
        n_in_eom   = r_in_eom;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
            if (s_axis_tvalid) begin
                n_in_op   = t_op'(s_axis_tuser);
                n_in_byte = s_axis_tdata;
                n_in_eom  = s_axis_tlast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes  <= '0;
            r_key_length <= KEY_LEN_W'(1);
            r_in_valid   <= 1'b0;
            r_chain      <= '0;
            r_kpos       <= '0;
            r_esc_pend   <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY_BYTES:  r_key_bytes  <= i_cfg_wdata;
                    REG_KEY_LENGTH: r_key_length <= i_cfg_wdata[KEY_LEN_W-1:0];
                    default: ;
                endcase
            end
            r_in_valid <= n_in_valid;
            r_chain    <= n_chain;
            r_kpos     <= n_kpos;
            r_esc_pend <= n_esc_pend;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_op   <= n_in_op;
        r_in_byte <= n_in_byte;
        r_in_eom  <= n_in_eom;
        r_b0      <= n_b0;
        r_l0      <= n_l0;
        r_b1      <= n_b1;
        r_l1      <= n_l1;
    end

    // The result register never holds more than an escape pair.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result register count out of range");

    // A full result register always presents the backslash of an escape first.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_b0 == CH_BACKSLASH && !r_l0 && r_l1))
        else $error("escape pair out of order");

    // The end of a message leaves the cipher state cleared.
    a_eom_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_eom) |=> (r_chain == '0 && r_kpos == '0 && !r_esc_pend))
        else $error("state not cleared after end of message");

    // An item that yields nothing leaves the master stream empty.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && res_cnt == 2'd0) |=> !m_axis_tvalid)
        else $error("result shown for an item without result");

    // Only a decrypt beat may yield no result.
    a_enc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_op == OP_ENCRYPT) |=> m_axis_tvalid)
        else $error("encrypt beat lost its result");

endmodule

@@ verif/tb_chained_xor_cipher_with_escaping.sv @@
// Self-checking testbench for the chained XOR cipher with escaping and unescaping.
`timescale 1ns / 1ps

module tb_chained_xor_cipher_with_escaping;
    import cxe_pkg::*;

    localparam int ITEMS_TOTAL = 1850;
    // Cycles without any beat on either stream before the run is declared hung.
    localparam int IDLE_LIMIT  = 200;
    // Cycles allowed for a beat that gives no result to leave the pipeline.
    localparam int DRAIN_CYCLES = 4;

    // Raw cipher values that need an escape, and the letter that follows the backslash.
    // Entry i of one list belongs to entry i of the other.
    localparam logic [4:0][BYTE_W-1:0] ESC_RAW =
        {CH_CR, CH_LF, CH_NUL, CH_BACKSLASH, CH_SOH};
    localparam logic [4:0][BYTE_W-1:0] ESC_LETTER =
        {CH_R, CH_N, CH_ZERO, CH_BACKSLASH, CH_A};
    // A character that is not a known escape letter.
    localparam logic [BYTE_W-1:0] CH_X = 8'h78;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [KEY_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    // Shadow copy of the cipher: registers and message state.
    logic [KEY_W-1:0]     key_reg = '0;
    logic [KEY_LEN_W-1:0] key_len_reg = 4'd1;
    logic [BYTE_W-1:0]    chain_q = '0;
    logic [2:0]           key_pos_q = '0;
    logic                 esc_pending_q = 1'b0;

    t_result out_bytes_due[$];
    t_result due;
    int      mismatches = 0;
    int      items_sent = 0;
    int      idle_cycles = 0;
    int      stall_left = 0;
    bit      gaps_on = 1'b1;
    bit      beat_moved = 1'b0;

    chained_xor_cipher_with_escaping uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // Works out the result bytes of one accepted input beat and advances the
    // shadow state. The key position moves only when a cipher byte is consumed.
    task automatic predict_cipher_bytes(input t_op op, input logic [BYTE_W-1:0] b,
                                        input logic eom);
        logic [BYTE_W-1:0] k, c, p, letter;
        logic              consumed, escaped;
        int                span, nxt;
        k = key_reg[key_pos_q*8 +: 8];
        span = (key_len_reg == 0) ? 1 :
               (key_len_reg > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : int'(key_len_reg);
        consumed = 1'b0;
        if (op == OP_ENCRYPT) begin
            c = chain_q ^ b ^ k;
            chain_q = chain_q ^ b;
            consumed = 1'b1;
            escaped = 1'b0;
            letter = '0;
            for (int i = 0; i < 5; i++) begin
                if (c == ESC_RAW[i]) begin
                    escaped = 1'b1;
                    letter = ESC_LETTER[i];
                end
            end
            if (escaped) begin
                out_bytes_due.push_back('{CH_BACKSLASH, 1'b0});
                out_bytes_due.push_back('{letter, 1'b1});
            end else begin
                out_bytes_due.push_back('{c, 1'b1});
            end
        end else begin
            c = b;
            if (esc_pending_q) begin
                // The byte after a backslash must be a known letter, else the pair is lost.
                esc_pending_q = 1'b0;
                for (int i = 0; i < 5; i++) begin
                    if (b == ESC_LETTER[i]) begin
                        consumed = 1'b1;
                        c = ESC_RAW[i];
                    end
                end
            end else if (b == CH_BACKSLASH) begin
                esc_pending_q = 1'b1;
            end else begin
                consumed = 1'b1;
            end
            if (consumed) begin
                p = chain_q ^ c ^ k;
                chain_q = chain_q ^ p;
                out_bytes_due.push_back('{p, 1'b1});
            end
        end
        if (consumed) begin
            // A stale position past a shrunk length still wraps to zero here.
            nxt = int'(key_pos_q) + 1;
            if (nxt >= span) nxt = 0;
            key_pos_q = nxt[2:0];
        end
        if (eom) begin
            chain_q = '0;
            key_pos_q = '0;
            esc_pending_q = 1'b0;
        end
    endtask

    // Sends one beat and returns at the edge where it is taken. Valid stays high
    // so that a following beat can go out back to back.
    task automatic send_byte(input t_op op, input logic [BYTE_W-1:0] b, input logic eom);
        int  gap;
        bit  took;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        s_axis_tlast  <= eom;
        do begin
            @(negedge i_clk);
            took = s_axis_tready;
            if (took) predict_cipher_bytes(op, b, eom);
            @(posedge i_clk);
        end while (!took);
        items_sent++;
    endtask

    // Picks the plaintext byte that enciphers to a chosen cipher value right now.
    task automatic send_enciphered(input logic [BYTE_W-1:0] target, input logic eom);
        send_byte(OP_ENCRYPT, target ^ chain_q ^ key_reg[key_pos_q*8 +: 8], eom);
    endtask

    // Holds the input idle until every predicted result has been seen, then lets
    // a silent beat leave the pipeline.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (out_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [KEY_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (index == REG_KEY_BYTES) key_reg = value;
        else key_len_reg = value[KEY_LEN_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Zero key and length one after reset: a zero byte enciphers to a NUL escape.
    task automatic test_reset_state();
        send_byte(OP_ENCRYPT, CH_NUL, 1'b0);
        send_byte(OP_ENCRYPT, 8'h41, 1'b1);
    endtask

    task automatic test_encrypt_escapes();
        write_reg(REG_KEY_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_KEY_LENGTH, 64'd5);
        for (int i = 0; i < 5; i++) send_enciphered(ESC_RAW[i], i == 4);
    endtask

    // Every known pair, an unknown pair, a raw NUL and a backslash left dangling
    // at the end of the message.
    task automatic test_decrypt_escapes();
        for (int i = 0; i < 5; i++) begin
            send_byte(OP_DECRYPT, CH_BACKSLASH, 1'b0);
            send_byte(OP_DECRYPT, ESC_LETTER[i], 1'b0);
        end
        send_byte(OP_DECRYPT, CH_BACKSLASH, 1'b0);
        send_byte(OP_DECRYPT, CH_X, 1'b0);
        send_byte(OP_DECRYPT, CH_NUL, 1'b0);
        send_byte(OP_DECRYPT, CH_BACKSLASH, 1'b1);
    endtask

    // The length drops to two while the position already sits at two.
    task automatic test_stale_key_position();
        write_reg(REG_KEY_BYTES, 64'hF0E1_D2C3_B4A5_9687);
        write_reg(REG_KEY_LENGTH, 64'd8);
        send_byte(OP_ENCRYPT, 8'h11, 1'b0);
        send_byte(OP_ENCRYPT, 8'h22, 1'b0);
        write_reg(REG_KEY_LENGTH, 64'd2);
        send_byte(OP_ENCRYPT, 8'h33, 1'b0);
        send_byte(OP_ENCRYPT, 8'h44, 1'b1);
    endtask

    // One message: plaintext, a well-formed escaped stream, or a mix of both
    // modes with stray backslashes and early message ends.
    task automatic random_message();
        int                len, kind, pick;
        logic [BYTE_W-1:0] b;
        logic              last;
        len  = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 10);
        kind = $urandom_range(0, 9);
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            pick = $urandom_range(0, 4);
            if (kind < 4) begin
                if ($urandom_range(0, 3) == 0) send_enciphered(ESC_RAW[pick], last);
                else send_byte(OP_ENCRYPT, BYTE_W'($urandom_range(0, 255)), last);
            end else if (kind < 8) begin
                b = BYTE_W'($urandom_range(0, 255));
                if ($urandom_range(0, 2) == 0 || b == CH_BACKSLASH) begin
                    if (b == CH_BACKSLASH) pick = 1;
                    send_byte(OP_DECRYPT, CH_BACKSLASH, 1'b0);
                    send_byte(OP_DECRYPT, ESC_LETTER[pick], last);
                end else begin
                    send_byte(OP_DECRYPT, b, last);
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: b = CH_BACKSLASH;
                    1: b = ($urandom_range(0, 5) == 0) ? CH_X : ESC_LETTER[pick];
                    default: b = BYTE_W'($urandom_range(0, 255));
                endcase
                send_byte(t_op'($urandom_range(0, 1)), b,
                          last || ($urandom_range(0, 19) == 0));
            end
        end
    endtask

    task automatic test_random_traffic();
        int                   msgs;
        logic [KEY_W-1:0]     key;
        logic [3:0][KEY_LEN_W-1:0] len_sweep;
        len_sweep = {4'd1, 4'd8, 4'd15, 4'd0};
        msgs = 0;
        while (items_sent < ITEMS_TOTAL) begin
            if (msgs % 12 == 0) begin
                case ($urandom_range(0, 5))
                    0: key = '0;
                    1: key = '1;
                    default: key = {$urandom, $urandom};
                endcase
                write_reg(REG_KEY_BYTES, key);
                // Sweep the length extremes first, then pick at random.
                write_reg(REG_KEY_LENGTH, (msgs / 12 < 4) ? 64'(len_sweep[msgs / 12]) :
                                          64'($urandom_range(0, 15)));
            end
            if (msgs == 40) wait_drained();
            if (items_sent > ITEMS_TOTAL - 300) gaps_on = 1'b0;
            random_message();
            msgs++;
        end
    endtask

    // Receiver stalls in bursts of random length while gaps are on.
    always @(posedge i_clk) begin
        if (stall_left > 0) stall_left--;
        else if (gaps_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 6);
        m_axis_tready <= (stall_left == 0);
    end

    // Outputs and tready settle after the rising edge, so the falling edge sees
    // exactly what the next rising edge will act on.
    always @(negedge i_clk) begin
        beat_moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (out_bytes_due.size() == 0) begin
                $error("result beat with none due: out_byte %h last_of_run %b",
                       m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                due = out_bytes_due.pop_front();
                if (m_axis_tdata !== due.out_byte) begin
                    $error("out_byte: expected %h, got %h", due.out_byte, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== due.last_of_run) begin
                    $error("last_of_run: expected %b, got %b", due.last_of_run, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (beat_moved) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_encrypt_escapes();
        test_decrypt_escapes();
        test_stale_key_position();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && out_bytes_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
